/* design/clipped_color_key_sprite_blit_core_assert.svh */
// assertion macros shared by the sprite blitter rtl
`ifndef CLIPPED_COLOR_KEY_SPRITE_BLIT_CORE_ASSERT_SVH
`define CLIPPED_COLOR_KEY_SPRITE_BLIT_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define CCKSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define CCKSB_ASSERT_NEVER(lbl, cond, msg) \
  `CCKSB_ASSERT(lbl, !(cond), msg)

`endif

/* design/ccksb_pkg.sv */
// shared types and register codes of the sprite blitter
`timescale 1ns / 1ps
`default_nettype none

package ccksb_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_POS_X      = 3'd0,
    REG_POS_Y      = 3'd1,
    REG_WIDTH      = 3'd2,
    REG_HEIGHT     = 3'd3,
    REG_ANCHOR_X   = 3'd4,
    REG_ANCHOR_Y   = 3'd5,
    REG_KEY_ENABLE = 3'd6,
    REG_KEY_COLOR  = 3'd7
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PIX_X_W    = 9;
  localparam int unsigned PIX_Y_W    = 8;
  localparam int unsigned COLOR_W    = 8;

  // one screen write
  typedef struct packed {
    logic [PIX_X_W-1:0] x;
    logic [PIX_Y_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               done;
  } pixel_t;

endpackage

`default_nettype wire

/* design/ccksb_out_skid.sv */
// output register with one skid entry for the screen write stream
`timescale 1ns / 1ps
`default_nettype none

`include "clipped_color_key_sprite_blit_core_assert.svh"

module ccksb_out_skid (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ccksb_pkg::pixel_t data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ccksb_pkg::pixel_t    data_o
);

  logic              o_valid_q, o_valid_d;
  logic              s_valid_q, s_valid_d;
  ccksb_pkg::pixel_t o_data_q, o_data_d;
  ccksb_pkg::pixel_t s_data_q, s_data_d;
  logic              o_free;

  // output slot can take new data this cycle
  assign o_free = !o_valid_q || !out_stall_i;

  always_comb begin
    o_valid_d = o_valid_q;
    s_valid_d = s_valid_q;
    o_data_d  = o_data_q;
    s_data_d  = s_data_q;
    if (o_free) begin
      if (s_valid_q) begin
        o_data_d  = s_data_q;
        o_valid_d = 1'b1;
        s_valid_d = 1'b0;
      end else if (push_i) begin
        o_data_d  = data_i;
        o_valid_d = 1'b1;
      end else begin
        o_valid_d = 1'b0;
      end
    end else if (push_i) begin
      s_data_d  = data_i;
      s_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_data_q <= o_data_d;
    s_data_q <= s_data_d;
  end

  assign full_o      = s_valid_q;
  assign out_valid_o = o_valid_q;
  assign data_o      = o_data_q;

  `CCKSB_ASSERT_NEVER(a_skid_without_out, s_valid_q && !o_valid_q, "skid entry held with empty output")
  `CCKSB_ASSERT(a_push_blocked_goes_skid, (push_i && o_valid_q && out_stall_i) |=> s_valid_q, "blocked transfer not kept in skid")

endmodule

`default_nettype wire

/* design/clipped_color_key_sprite_blit_core.sv */
// top level of the colour keyed sprite blitter with per pixel clipping
// a visible texel's screen write leaves via the output register, through the skid entry if stalled
// throughput: one texel per cycle while the skid entry is free, set by the single compute stage and the output register
// a one entry skid lets a texel be taken while the output is stalled; input stalls when it is full
// reset: counters and valid flags clear, registers take their reset values (size 16 by 16)
`timescale 1ns / 1ps
`default_nettype none

`include "clipped_color_key_sprite_blit_core_assert.svh"

module clipped_color_key_sprite_blit_core #(
  parameter int unsigned SCREEN_W   = 320,
  parameter int unsigned SCREEN_H   = 200,
  parameter int unsigned MAX_SPRITE = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [2:0]                      cfg_index_i,
  input  wire logic [ccksb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // texel stream
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      in_texel_i,
  // screen write stream
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [8:0]                           out_pixel_x_o,
  output logic [7:0]                           out_pixel_y_o,
  output logic [7:0]                           out_pixel_color_o,
  output logic                                 out_sprite_done_o
);

  // counter width holds MAX_SPRITE - 1
  localparam int unsigned CNT_W = (MAX_SPRITE > 1) ? $clog2(MAX_SPRITE) : 1;
  // coordinate width: signed position less anchor plus counter, with headroom
  localparam int unsigned CW    = ((CNT_W > 10) ? CNT_W : 10) + 3;
  // width for comparing a size register against MAX_SPRITE
  localparam int unsigned SW    = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam logic [CW-1:0]    SCR_W_C    = CW'(SCREEN_W);
  localparam logic [CW-1:0]    SCR_H_C    = CW'(SCREEN_H);
  localparam logic [SW-1:0]    MAX_SZ_C   = SW'(MAX_SPRITE);
  localparam logic [CNT_W-1:0] MAX_LAST_C = CNT_W'(MAX_SPRITE - 1);

  // configuration registers
  logic signed [10:0] pos_x_q, pos_y_q;
  logic [8:0]         width_q, height_q;
  logic [7:0]         anchor_x_q, anchor_y_q;
  logic               key_en_q;
  logic [7:0]         key_color_q;

  // raster position inside the sprite
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;

  logic              accept;
  logic [CNT_W-1:0]  w_last, h_last;
  logic              row_end, last;
  logic [CW-1:0]     x, y;
  logic              on_screen, keyed, visible;
  logic              skid_full;
  ccksb_pkg::pixel_t pix, pix_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      width_q     <= 9'd16;
      height_q    <= 9'd16;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      key_en_q    <= 1'b0;
      key_color_q <= '0;
    end else if (cfg_we_i) begin
      case (ccksb_pkg::cfg_reg_e'(cfg_index_i))
        ccksb_pkg::REG_POS_X:      pos_x_q     <= $signed(cfg_data_i[10:0]);
        ccksb_pkg::REG_POS_Y:      pos_y_q     <= $signed(cfg_data_i[10:0]);
        ccksb_pkg::REG_WIDTH:      width_q     <= cfg_data_i[8:0];
        ccksb_pkg::REG_HEIGHT:     height_q    <= cfg_data_i[8:0];
        ccksb_pkg::REG_ANCHOR_X:   anchor_x_q  <= cfg_data_i[7:0];
        ccksb_pkg::REG_ANCHOR_Y:   anchor_y_q  <= cfg_data_i[7:0];
        ccksb_pkg::REG_KEY_ENABLE: key_en_q    <= cfg_data_i[0];
        ccksb_pkg::REG_KEY_COLOR:  key_color_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // texel taken when the skid entry is free
  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  // last column and row index; zero or oversized sizes fall back to MAX_SPRITE
  always_comb begin
    if (width_q == 9'd0 || SW'(width_q) > MAX_SZ_C) begin
      w_last = MAX_LAST_C;
    end else begin
      w_last = CNT_W'(width_q - 9'd1);
    end
    if (height_q == 9'd0 || SW'(height_q) > MAX_SZ_C) begin
      h_last = MAX_LAST_C;
    end else begin
      h_last = CNT_W'(height_q - 9'd1);
    end
  end

  // a counter at or past its last index ends the row or the sprite
  assign row_end = col_q >= w_last;
  assign last    = row_end && (row_q >= h_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // screen point: position less anchor plus raster offset, sign extended
  assign x = {{(CW-11){pos_x_q[10]}}, pos_x_q} - {{(CW-8){1'b0}}, anchor_x_q}
           + {{(CW-CNT_W){1'b0}}, col_q};
  assign y = {{(CW-11){pos_y_q[10]}}, pos_y_q} - {{(CW-8){1'b0}}, anchor_y_q}
           + {{(CW-CNT_W){1'b0}}, row_q};

  // per pixel clip, so sprites off the left or top edge are cut correctly
  assign on_screen = !x[CW-1] && (x < SCR_W_C) && !y[CW-1] && (y < SCR_H_C);
  assign keyed     = key_en_q && (in_texel_i == key_color_q);
  assign visible   = on_screen && !keyed;

  // coordinates masked to the field widths for wide screens
  always_comb begin
    pix.x     = x[8:0];
    pix.y     = y[7:0];
    pix.color = in_texel_i;
    pix.done  = last;
  end

  ccksb_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && visible),
    .data_i      (pix),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (pix_out)
  );

  assign out_pixel_x_o     = pix_out.x;
  assign out_pixel_y_o     = pix_out.y;
  assign out_pixel_color_o = pix_out.color;
  assign out_sprite_done_o = pix_out.done;

  `CCKSB_ASSERT(a_wrap_at_sprite_end, (accept && last) |=> (col_q == '0 && row_q == '0), "counters did not wrap at end of sprite")
  `CCKSB_ASSERT(a_idle_counters_hold, !accept |=> ($stable(col_q) && $stable(row_q)), "counters moved without a texel transfer")

endmodule

`default_nettype wire
